### src/dsmd_pkg.sv
// Shared constants and types of the depth slice median deprojection block.
package dsmd_pkg;

    localparam int MAX_SLICE_ROWS = 8;
    localparam int LANE_IDX_W = $clog2(MAX_SLICE_ROWS);
    localparam int ROWS_W = $clog2(MAX_SLICE_ROWS + 1);
    localparam int DEPTH_W = 16;
    localparam int CFG_W = 20;
    localparam int DEN_W = 20;
    localparam int NUM_W = 37;

    localparam logic [2:0] REG_FOCAL_X = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y = 3'd1;
    localparam logic [2:0] REG_CENTRE_X = 3'd2;
    localparam logic [2:0] REG_CENTRE_Y = 3'd3;
    localparam logic [2:0] REG_IMAGE_WIDTH = 3'd4;
    localparam logic [2:0] REG_MIN_DEPTH = 3'd5;
    localparam logic [2:0] REG_MAX_DEPTH = 3'd6;

    typedef logic [MAX_SLICE_ROWS-1:0][DEPTH_W-1:0] depth_arr_t;

    typedef struct packed {
        logic                  valid;
        logic [LANE_IDX_W-1:0] rank;
    } lane_res_t;

    typedef struct packed {
        logic                ok;
        logic                neg_x;
        logic                neg_y;
        logic [DEPTH_W-1:0]  z;
    } side_t;

endpackage

### src/dsmd_lane.sv
// One median lane: validity and ascending rank of one depth sample.
module dsmd_lane (
    input  dsmd_pkg::depth_arr_t                depths,
    input  logic [dsmd_pkg::MAX_SLICE_ROWS-1:0] in_use,
    input  logic [dsmd_pkg::LANE_IDX_W-1:0]     lane_idx,
    output dsmd_pkg::lane_res_t                 res
);

    logic [dsmd_pkg::ROWS_W-1:0] cnt;
    logic [dsmd_pkg::DEPTH_W-1:0] mine;

    always_comb
    begin
        mine = depths[lane_idx];
        cnt = '0;
        for (int j = 0; j < dsmd_pkg::MAX_SLICE_ROWS; j++)
        begin
            if (in_use[j] && ((depths[j] < mine) ||
                (depths[j] == mine && j[dsmd_pkg::LANE_IDX_W-1:0] < lane_idx)))
            begin
                cnt = cnt + 1'b1;
            end
        end
        res.valid = in_use[lane_idx];
        res.rank = cnt[dsmd_pkg::LANE_IDX_W-1:0];
    end

endmodule

### src/dsmd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module dsmd_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [dsmd_pkg::NUM_W-1:0]   num,
    input  logic [dsmd_pkg::DEN_W-1:0]   den,
    output logic [dsmd_pkg::NUM_W-1:0]   quo
);

    localparam int N = dsmd_pkg::NUM_W;
    localparam int D = dsmd_pkg::DEN_W;

    logic [N-1:0][D-1:0] rem_reg;
    logic [N-1:0][N-1:0] num_reg;
    logic [N-1:0][N-1:0] quo_reg;
    logic [N-1:0][D-1:0] den_reg;

    genvar s;
    generate
        for (s = 0; s < N; s++)
        begin : g_stage
            logic [D-1:0] rem_in;
            logic [N-1:0] num_in;
            logic [N-1:0] quo_in;
            logic [D-1:0] den_in;
            logic [D:0]   trial;
            logic [D:0]   diff;
            logic         take;
            logic [D-1:0] rem_next;

            if (s == 0)
            begin : g_first
                assign rem_in = '0;
                assign num_in = num;
                assign quo_in = '0;
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign num_in = num_reg[s-1];
                assign quo_in = quo_reg[s-1];
                assign den_in = den_reg[s-1];
            end

            always_comb
            begin
                trial = {rem_in, num_in[N-1]};
                diff = trial - {1'b0, den_in};
                take = trial >= {1'b0, den_in};
                rem_next = take ? diff[D-1:0] : trial[D-1:0];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next;
                    num_reg[s] <= {num_in[N-2:0], 1'b0};
                    quo_reg[s] <= {quo_in[N-2:0], take};
                    den_reg[s] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[N-1];

endmodule

### src/depth_slice_median_deproject.sv
// Top level: median of slice depths per ray and pinhole back-projection.
// An accepted input word passes stages 1 to 5, the divider pipeline and the output register.
// Throughput: one word per cycle while the pipeline advances; the 37-stage divider pipeline sets the depth.
// The whole pipeline advances together when the output register is free or taken.
// rst_n clears all valid flags and loads the default camera registers.
module depth_slice_median_deproject (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [19:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // depth_0..depth_7, row_count, column_q8, centre_row, zero pad
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // point_x, point_y, point_z
    output logic [79:0]  m_tdata,
    // point_valid
    output logic [0:0]   m_tuser
);

    localparam int R = dsmd_pkg::MAX_SLICE_ROWS;
    localparam int DW = dsmd_pkg::DEPTH_W;
    localparam int N = dsmd_pkg::NUM_W;

    logic [19:0] fx_reg, fy_reg, cx_reg, cy_reg;
    logic [12:0] width_reg;
    logic [15:0] min_reg, max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg <= 20'd128000;
            fy_reg <= 20'd128000;
            cx_reg <= 20'd81920;
            cy_reg <= 20'd61440;
            width_reg <= 13'd640;
            min_reg <= 16'd800;
            max_reg <= 16'd36000;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                dsmd_pkg::REG_FOCAL_X: fx_reg <= cfg_data;
                dsmd_pkg::REG_FOCAL_Y: fy_reg <= cfg_data;
                dsmd_pkg::REG_CENTRE_X: cx_reg <= cfg_data;
                dsmd_pkg::REG_CENTRE_Y: cy_reg <= cfg_data;
                dsmd_pkg::REG_IMAGE_WIDTH: width_reg <= cfg_data[12:0];
                dsmd_pkg::REG_MIN_DEPTH: min_reg <= cfg_data[15:0];
                dsmd_pkg::REG_MAX_DEPTH: max_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || m_tready;
    assign s_tready = en;

    // stage 1: capture input
    logic v1_reg;
    dsmd_pkg::depth_arr_t d1_reg;
    logic [R-1:0] use1_reg;
    logic [20:0] col1_reg;
    logic [11:0] crow1_reg;
    logic [R-1:0] use_next;
    logic [3:0] rows_in;

    always_comb
    begin
        rows_in = s_tdata[131:128];
        for (int i = 0; i < R; i++)
        begin
            use_next[i] = (rows_in > i[3:0]) && (s_tdata[i*16 +: 16] != 16'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < R; i++)
            begin
                d1_reg[i] <= s_tdata[i*16 +: 16];
            end
            use1_reg <= use_next;
            col1_reg <= s_tdata[152:132];
            crow1_reg <= s_tdata[164:153];
        end
    end

    // stage 2: lane ranks
    dsmd_pkg::lane_res_t [R-1:0] lane_res;
    genvar g;
    generate
        for (g = 0; g < R; g++)
        begin : g_lane
            dsmd_lane u_lane (
                .depths  (d1_reg),
                .in_use  (use1_reg),
                .lane_idx(g[dsmd_pkg::LANE_IDX_W-1:0]),
                .res     (lane_res[g])
            );
        end
    endgenerate

    logic v2_reg;
    dsmd_pkg::lane_res_t [R-1:0] res2_reg;
    dsmd_pkg::depth_arr_t d2_reg;
    logic [dsmd_pkg::ROWS_W-1:0] n2_reg;
    logic [20:0] col2_reg;
    logic [11:0] crow2_reg;
    logic [dsmd_pkg::ROWS_W-1:0] n_next;

    always_comb
    begin
        n_next = '0;
        for (int i = 0; i < R; i++)
        begin
            n_next = n_next + {{(dsmd_pkg::ROWS_W-1){1'b0}}, use1_reg[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res2_reg <= lane_res;
            d2_reg <= d1_reg;
            n2_reg <= n_next;
            col2_reg <= col1_reg;
            crow2_reg <= crow1_reg;
        end
    end

    // stage 3: merge lanes, checks, offsets
    logic [DW-1:0] z_sel;
    logic col_ok, ok_next;
    logic [21:0] dx_next, dy_next;
    logic [dsmd_pkg::LANE_IDX_W-1:0] mid;

    always_comb
    begin
        mid = n2_reg[dsmd_pkg::ROWS_W-1:1];
        z_sel = '0;
        for (int i = 0; i < R; i++)
        begin
            if (res2_reg[i].valid && res2_reg[i].rank == mid)
            begin
                z_sel = z_sel | d2_reg[i];
            end
        end
        col_ok = !col2_reg[20] && ({1'b0, col2_reg[19:0]} < {width_reg, 8'd0});
        ok_next = col_ok && (n2_reg != '0) && (z_sel >= min_reg) && (z_sel <= max_reg);
        dx_next = {1'b0, col2_reg} - {2'b00, cx_reg};
        dy_next = {2'b00, crow2_reg, 8'd0} - {2'b00, cy_reg};
    end

    logic v3_reg, ok3_reg;
    logic [DW-1:0] z3_reg;
    logic [21:0] dx3_reg, dy3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok3_reg <= ok_next;
            z3_reg <= z_sel;
            dx3_reg <= dx_next;
            dy3_reg <= dy_next;
        end
    end

    // stage 4: products
    logic v4_reg, ok4_reg;
    logic [DW-1:0] z4_reg;
    logic signed [38:0] px4_reg, py4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok4_reg <= ok3_reg;
            z4_reg <= z3_reg;
            px4_reg <= 39'($signed(dx3_reg) * $signed({1'b0, z3_reg}));
            py4_reg <= 39'($signed(dy3_reg) * $signed({1'b0, z3_reg}));
        end
    end

    // stage 5: magnitude plus half divisor
    logic [19:0] fxe, fye;
    logic [38:0] magx, magy;
    assign fxe = (fx_reg == '0) ? 20'd1 : fx_reg;
    assign fye = (fy_reg == '0) ? 20'd1 : fy_reg;
    assign magx = px4_reg[38] ? 39'(-px4_reg) : px4_reg;
    assign magy = py4_reg[38] ? 39'(-py4_reg) : py4_reg;

    logic v5_reg;
    dsmd_pkg::side_t side5_reg;
    logic [N-1:0] numx5_reg, numy5_reg;
    logic [19:0] fx5_reg, fy5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side5_reg.ok <= ok4_reg;
            side5_reg.z <= z4_reg;
            side5_reg.neg_x <= px4_reg[38];
            side5_reg.neg_y <= py4_reg[38];
            numx5_reg <= magx[N-1:0] + {{(N-19){1'b0}}, fxe[19:1]};
            numy5_reg <= magy[N-1:0] + {{(N-19){1'b0}}, fye[19:1]};
            fx5_reg <= fxe;
            fy5_reg <= fye;
        end
    end

    logic [N-1:0] qx, qy;
    dsmd_div u_div_x (.clk(clk), .en(en), .num(numx5_reg), .den(fx5_reg), .quo(qx));
    dsmd_div u_div_y (.clk(clk), .en(en), .num(numy5_reg), .den(fy5_reg), .quo(qy));

    dsmd_pkg::side_t [N-1:0] side_pipe_reg;
    logic [N-1:0] vpipe_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_pipe_reg[0] <= side5_reg;
            for (int i = 1; i < N; i++)
            begin
                side_pipe_reg[i] <= side_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vpipe_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            vpipe_reg <= {vpipe_reg[N-2:0], v5_reg};
            out_valid_reg <= vpipe_reg[N-1];
        end
    end

    // output: sign, saturate, zero on reject
    function automatic logic [31:0] sat_sign(input logic neg, input logic [N-1:0] q);
        logic [31:0] r;
        if (!neg)
        begin
            r = (q > {{(N-31){1'b0}}, 31'h7FFFFFFF}) ? 32'h7FFFFFFF : q[31:0];
        end
        else
        begin
            r = (q > {{(N-32){1'b0}}, 32'h80000000}) ? 32'h80000000 : 32'(-q[31:0]);
        end
        return r;
    endfunction

    dsmd_pkg::side_t side_out;
    assign side_out = side_pipe_reg[N-1];

    logic [31:0] x_reg, y_reg;
    logic [15:0] z_reg;
    logic pv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pv_reg <= side_out.ok;
            x_reg <= side_out.ok ? sat_sign(side_out.neg_x, qx) : 32'd0;
            y_reg <= side_out.ok ? sat_sign(side_out.neg_y, qy) : 32'd0;
            z_reg <= side_out.ok ? side_out.z : 16'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {z_reg, y_reg, x_reg};
    assign m_tuser = pv_reg;

endmodule
